>>> sv/indexed_array_insert_delete_search_macros.svh
// Assertion macros shared by the array controller and datapath.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef INDEXED_ARRAY_INSERT_DELETE_SEARCH_MACROS_SVH
`define INDEXED_ARRAY_INSERT_DELETE_SEARCH_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define IAIDS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define IAIDS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/iaids_pkg.sv
package iaids_pkg;

  localparam int OP_W   = 3;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int FIDX_W = 6;
  localparam int SIZE_W = 7;

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [STAT_W-1:0] status_t;

  localparam op_t OP_INSERT = 3'd0;
  localparam op_t OP_DELETE = 3'd1;
  localparam op_t OP_UPDATE = 3'd2;
  localparam op_t OP_READ   = 3'd3;
  localparam op_t OP_SEARCH = 3'd4;
  localparam op_t OP_CLEAR  = 3'd5;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_RANGE    = 2'd1;
  localparam status_t ST_FULL     = 2'd2;
  localparam status_t ST_NOTFOUND = 2'd3;

  // Read address select
  typedef logic [1:0] rsel_t;
  localparam rsel_t RSEL_POS   = 2'd0;
  localparam rsel_t RSEL_IDX   = 2'd1;
  localparam rsel_t RSEL_SHIFT = 2'd2;

  // Write source select
  typedef logic wsel_t;
  localparam wsel_t WSEL_POS   = 1'b0;
  localparam wsel_t WSEL_SHIFT = 1'b1;

  // Size update
  typedef logic [1:0] szop_t;
  localparam szop_t SZ_HOLD = 2'd0;
  localparam szop_t SZ_INC  = 2'd1;
  localparam szop_t SZ_DEC  = 2'd2;
  localparam szop_t SZ_CLR  = 2'd3;

  typedef struct packed {
    logic    capture;
    logic    idx_init;
    logic    idx_step;
    logic    mem_rd;
    rsel_t   rd_sel;
    logic    mem_wr;
    wsel_t   wr_sel;
    szop_t   size_op;
    logic    st_load;
    status_t st_code;
    logic    rd_capture;
    logic    fidx_capture;
    logic    out_load;
  } ctl_cmd_t;

  typedef struct packed {
    op_t  opcode;
    logic range_ins;
    logic range_acc;
    logic full;
    logic shift_last;
    logic srch_end;
    logic match;
  } dp_stat_t;

endpackage

>>> sv/iaids_ram.sv
module iaids_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/iaids_ctrl.sv
`include "indexed_array_insert_delete_search_macros.svh"

module iaids_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  iaids_pkg::dp_stat_t stat,
  output iaids_pkg::ctl_cmd_t cmd
);

  import iaids_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_SHIFT_RD = 3'd2;
  localparam logic [2:0] S_SHIFT_WR = 3'd3;
  localparam logic [2:0] S_SRCH_RD  = 3'd4;
  localparam logic [2:0] S_SRCH_CMP = 3'd5;
  localparam logic [2:0] S_READ     = 3'd6;
  localparam logic [2:0] S_FINISH   = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_FINISH;
        unique case (stat.opcode)
          OP_INSERT: begin
            if (stat.range_ins) begin
              cmd.st_load = 1'b1;
              cmd.st_code = ST_RANGE;
            end else if (stat.full) begin
              cmd.st_load = 1'b1;
              cmd.st_code = ST_FULL;
            end else begin
              cmd.idx_init = 1'b1;
              state_nxt    = S_SHIFT_RD;
            end
          end
          OP_DELETE: begin
            if (stat.range_acc) begin
              cmd.st_load = 1'b1;
              cmd.st_code = ST_RANGE;
            end else begin
              cmd.idx_init = 1'b1;
              state_nxt    = S_SHIFT_RD;
            end
          end
          OP_UPDATE: begin
            if (stat.range_acc) begin
              cmd.st_load = 1'b1;
              cmd.st_code = ST_RANGE;
            end else begin
              cmd.mem_wr = 1'b1;
              cmd.wr_sel = WSEL_POS;
            end
          end
          OP_READ: begin
            if (stat.range_acc) begin
              cmd.st_load = 1'b1;
              cmd.st_code = ST_RANGE;
            end else begin
              cmd.mem_rd = 1'b1;
              cmd.rd_sel = RSEL_POS;
              state_nxt  = S_READ;
            end
          end
          OP_SEARCH: begin
            cmd.idx_init = 1'b1;
            state_nxt    = S_SRCH_RD;
          end
          OP_CLEAR: begin
            cmd.size_op = SZ_CLR;
          end
          default: begin
          end
        endcase
      end
      S_SHIFT_RD: begin
        if (stat.shift_last) begin
          if (stat.opcode == OP_INSERT) begin
            cmd.mem_wr  = 1'b1;
            cmd.wr_sel  = WSEL_POS;
            cmd.size_op = SZ_INC;
          end else begin
            cmd.size_op = SZ_DEC;
          end
          state_nxt = S_FINISH;
        end else begin
          cmd.mem_rd = 1'b1;
          cmd.rd_sel = RSEL_SHIFT;
          state_nxt  = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.mem_wr   = 1'b1;
        cmd.wr_sel   = WSEL_SHIFT;
        cmd.idx_step = 1'b1;
        state_nxt    = S_SHIFT_RD;
      end
      S_SRCH_RD: begin
        if (stat.srch_end) begin
          cmd.st_load = 1'b1;
          cmd.st_code = ST_NOTFOUND;
          state_nxt   = S_FINISH;
        end else begin
          cmd.mem_rd = 1'b1;
          cmd.rd_sel = RSEL_IDX;
          state_nxt  = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (stat.match) begin
          cmd.fidx_capture = 1'b1;
          state_nxt        = S_FINISH;
        end else begin
          cmd.idx_step = 1'b1;
          state_nxt    = S_SRCH_RD;
        end
      end
      S_READ: begin
        cmd.rd_capture = 1'b1;
        state_nxt      = S_FINISH;
      end
      S_FINISH: begin
        // hold the result until the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE) || !rst_n;
  assign out_valid = out_valid_r;

  `IAIDS_ASSERT_IMP(a_load_slot_free, cmd.out_load, !out_valid_r || !out_stall, "result overwritten")
  `IAIDS_ASSERT_IMP(a_wr_after_rd, state_r == S_SHIFT_WR, $past(state_r) == S_SHIFT_RD, "shift write without read")
  `IAIDS_ASSERT_NXT(a_accept_dispatch, state_r == S_IDLE && in_valid, state_r == S_DISPATCH, "accept lost")

endmodule

>>> sv/iaids_dp.sv
`include "indexed_array_insert_delete_search_macros.svh"

module iaids_dp #(
  parameter int DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  iaids_pkg::op_t                    in_opcode,
  input  logic [iaids_pkg::POS_W-1:0]       in_position,
  input  logic signed [iaids_pkg::VAL_W-1:0] in_value,
  input  iaids_pkg::ctl_cmd_t               cmd,
  output iaids_pkg::dp_stat_t               stat,
  output iaids_pkg::status_t                out_status,
  output logic signed [iaids_pkg::VAL_W-1:0] out_read_value,
  output logic [iaids_pkg::FIDX_W-1:0]      out_found_index,
  output logic [iaids_pkg::SIZE_W-1:0]      out_size_after
);

  import iaids_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  op_t                     op_r;
  logic [POS_W-1:0]        pos_r;
  logic [VAL_W-1:0]        val_r;
  logic [CW-1:0]           size_r, size_nxt;
  logic [CW-1:0]           idx_r;
  status_t                 res_status_r;
  logic [VAL_W-1:0]        res_rd_r;
  logic [FIDX_W-1:0]       res_fidx_r;

  logic [XW-1:0]           pos_x, size_x, idx_x;
  logic [CW-1:0]           idx_inc, idx_dec, idx_init_val;
  logic [IW-1:0]           pos_addr, idx_addr, shift_addr;
  logic [IW-1:0]           raddr, waddr;
  logic [VAL_W-1:0]        rdata, wdata;
  logic                    is_insert;

  assign pos_x     = XW'(pos_r);
  assign size_x    = XW'(size_r);
  assign idx_x     = XW'(idx_r);
  assign idx_inc   = idx_r + CW'(1);
  assign idx_dec   = idx_r - CW'(1);
  assign is_insert = (op_r == OP_INSERT);

  assign pos_addr   = pos_x[IW-1:0];
  assign idx_addr   = idx_r[IW-1:0];
  assign shift_addr = is_insert ? idx_dec[IW-1:0] : idx_inc[IW-1:0];

  always_comb begin
    case (cmd.rd_sel)
      RSEL_IDX:   raddr = idx_addr;
      RSEL_SHIFT: raddr = shift_addr;
      default:    raddr = pos_addr;
    endcase
  end

  assign waddr = (cmd.wr_sel == WSEL_SHIFT) ? idx_addr : pos_addr;
  assign wdata = (cmd.wr_sel == WSEL_SHIFT) ? rdata : val_r;

  iaids_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.mem_wr),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.mem_rd),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    case (op_r)
      OP_INSERT: idx_init_val = size_r;
      OP_DELETE: idx_init_val = pos_x[CW-1:0];
      default:   idx_init_val = '0;
    endcase
  end

  always_comb begin
    case (cmd.size_op)
      SZ_INC:  size_nxt = size_r + CW'(1);
      SZ_DEC:  size_nxt = size_r - CW'(1);
      SZ_CLR:  size_nxt = '0;
      default: size_nxt = size_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= '0;
    end else begin
      size_r <= size_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r         <= in_opcode;
      pos_r        <= in_position;
      val_r        <= $unsigned(in_value);
      res_status_r <= ST_OK;
      res_rd_r     <= '0;
      res_fidx_r   <= '0;
    end
    if (cmd.st_load) begin
      res_status_r <= cmd.st_code;
    end
    if (cmd.rd_capture) begin
      res_rd_r <= rdata;
    end
    if (cmd.fidx_capture) begin
      res_fidx_r <= idx_x[FIDX_W-1:0];
    end
    if (cmd.idx_init) begin
      idx_r <= idx_init_val;
    end else if (cmd.idx_step) begin
      idx_r <= is_insert ? idx_dec : idx_inc;
    end
    if (cmd.out_load) begin
      out_status      <= res_status_r;
      out_read_value  <= $signed(res_rd_r);
      out_found_index <= res_fidx_r;
      out_size_after  <= size_x[SIZE_W-1:0];
    end
  end

  assign stat.opcode     = op_r;
  assign stat.range_ins  = (pos_x > size_x);
  assign stat.range_acc  = (pos_x >= size_x);
  assign stat.full       = (size_r == CW'(DEPTH));
  assign stat.shift_last = is_insert ? (idx_x == pos_x) : (idx_inc >= size_r);
  assign stat.srch_end   = (idx_r >= size_r);
  assign stat.match      = (rdata == val_r);

  `IAIDS_ASSERT_IMP(a_size_bound, 1'b1, size_r <= CW'(DEPTH), "size beyond depth")
  `IAIDS_ASSERT_IMP(a_one_port_op, cmd.mem_wr, !cmd.mem_rd, "read and write in one cycle")
  `IAIDS_ASSERT_IMP(a_inc_not_full, cmd.size_op == SZ_INC, !stat.full, "insert into full array")

endmodule

>>> sv/indexed_array_insert_delete_search.sv
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+----------------------------------------------
// in_      | input     | in_valid / in_stall | opcode, position, value
// out_     | output    | out_valid/out_stall | status, read_value, found_index, size_after
//
// One request at a time. Entries are moved or scanned one at a time: insert and
// delete move each entry with a read state and then a write state, and search reads
// each entry and then compares it. The element RAM has a registered read, so each
// read is followed by a state that uses the read data.
// Reset (rst_n low, synchronous) empties the array and holds in_stall high; the RAM
// needs no clearing pass.
// A stalled result holds in the output register; the next request is accepted
// meanwhile and waits at completion until the register frees.
module indexed_array_insert_delete_search #(
  parameter int DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  iaids_pkg::op_t                     in_opcode,
  input  logic [iaids_pkg::POS_W-1:0]        in_position,
  input  logic signed [iaids_pkg::VAL_W-1:0] in_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output iaids_pkg::status_t                 out_status,
  output logic signed [iaids_pkg::VAL_W-1:0] out_read_value,
  output logic [iaids_pkg::FIDX_W-1:0]       out_found_index,
  output logic [iaids_pkg::SIZE_W-1:0]       out_size_after
);

  import iaids_pkg::*;

  // controller sequences, datapath holds array, size and result registers
  ctl_cmd_t cmd;
  dp_stat_t stat;

  iaids_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // shift entries one per read/write pair, scan one entry per compare
  iaids_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_opcode       (in_opcode),
    .in_position     (in_position),
    .in_value        (in_value),
    .cmd             (cmd),
    .stat            (stat),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_found_index (out_found_index),
    .out_size_after  (out_size_after)
  );

endmodule
